// File: src/fbd_pkg.sv
// shared types and constants for the fractional baud divider calculation
// used by the serial divider and the top level; no dependencies
`default_nettype none

package fbd_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int EXP_W      = 4;
  localparam int DIVISOR_W  = 12;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_CORE_CLOCK   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_SPEED = 1'd1;

  localparam logic [DATA_W-1:0] CORE_CLOCK_RESET = 32'd32000000;

  // rate limits: clock/8 and clock/4194304 as shifts
  localparam int MAX_DIV_SH = 3;
  localparam int MIN_DIV_SH = 22;

  // exponent search: limit starts at 0xfff >> 4, exponent at -7
  localparam logic [DATA_W-1:0]       LIM_INIT = 32'h0000_0fff >> 4;
  localparam logic signed [EXP_W-1:0] EXP_MIN  = -4'sd7;
  localparam logic signed [EXP_W-1:0] EXP_MAX  = 4'sd7;
  localparam logic signed [EXP_W-1:0] EXP_OFS  = 4'sd3;

  // request into the shared divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  // status back from the shared divider
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: src/fbd_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on fbd_pkg for widths and request/status structs
`default_nettype none

module fbd_div
  import fbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quot_r, quot_nxt;
  logic [DATA_W-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // one restoring step on the running remainder
  always_comb begin
    trial    = {rem_r, quot_r[DATA_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    quot_nxt = {quot_r[DATA_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end else if (req.start) begin
      rem_r  <= '0;
      quot_r <= req.num;
      den_r  <= req.den;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// File: src/fractional_baud_divider_calc.sv
// sequence per item: range check, a ratio pass on the shared divider, the exponent search,
// set-up, a second divider pass and hand-over to the result register; a rejected rate
// goes from the check straight to hand-over
// throughput: one item at a time, the next taken the cycle after the result is registered,
// and later while the result channel stalls
// reset (rst_n low, synchronous): core clock 32000000, single speed, no result pending
`default_nettype none

module fractional_baud_divider_calc
  import fbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [DATA_W-1:0]     cfg_wdata,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DATA_W-1:0]     in_baud_rate,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_ok,
  output logic signed [EXP_W-1:0]    out_scale_exp,
  output logic [DIVISOR_W-1:0]       out_divisor
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RATIO_WAIT, S_SEARCH, S_PREP, S_DIV_WAIT, S_DONE
  } state_t;

  state_t state_r;

  logic [DATA_W-1:0]       clk_hz_r;
  logic                    ds_r;
  logic [DATA_W-1:0]       rate_r;
  logic [DATA_W-1:0]       ratio_r;
  logic [DATA_W-1:0]       lim_r;
  logic signed [EXP_W-1:0] exp_r;
  logic                    nonneg_r;
  logic                    den_zero_r;
  logic                    res_ok_r;
  logic signed [EXP_W-1:0] res_exp_r;
  logic [DIVISOR_W-1:0]    res_div_r;
  logic                    out_valid_r;
  logic                    out_ok_r;
  logic signed [EXP_W-1:0] out_exp_r;
  logic [DIVISOR_W-1:0]    out_div_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DATA_W-1:0] hi, lo, rate2;
  logic              reject;
  logic [DATA_W-1:0] clk_m;
  logic [EXP_W-1:0]  sh_pos, sh_neg;
  logic [DATA_W-1:0] den_sh;
  logic [DATA_W-1:0] prep_num, prep_den;
  logic [DATA_W-1:0] q_raw;
  logic              out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CORE_CLOCK_RESET;
      ds_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CORE_CLOCK:   clk_hz_r <= cfg_wdata;
        REG_DOUBLE_SPEED: ds_r     <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // range check, limits halve in single speed
  always_comb begin
    hi     = ds_r ? (clk_hz_r >> MAX_DIV_SH) : (clk_hz_r >> (MAX_DIV_SH + 1));
    lo     = ds_r ? (clk_hz_r >> MIN_DIV_SH) : (clk_hz_r >> (MIN_DIV_SH + 1));
    reject = (rate_r > hi) || (rate_r < lo) || (rate_r == '0);
    rate2  = ds_r ? rate_r : (rate_r << 1);
  end

  // divisor operands from the chosen exponent
  always_comb begin
    clk_m    = clk_hz_r - (rate_r << 3);
    sh_pos   = exp_r + EXP_OFS;
    sh_neg   = -exp_r - EXP_OFS;
    den_sh   = rate_r << sh_pos;
    prep_num = clk_hz_r + (den_sh >> 1);
    prep_den = den_sh;
    if (exp_r <= -EXP_OFS) begin
      prep_num = (clk_m << sh_neg) + (rate_r >> 1);
      prep_den = rate_r;
    end else if (exp_r < 4'sd0) begin
      prep_num = clk_m + (den_sh >> 1);
    end
  end

  // shared divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = clk_hz_r;
    div_req.den   = rate2;
    case (state_r)
      S_CHECK: div_req.start = !reject;
      S_PREP: begin
        div_req.start = 1'b1;
        div_req.num   = prep_num;
        div_req.den   = prep_den;
      end
      default: ;
    endcase
  end

  fbd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign q_raw    = den_zero_r ? '0 : div_rsp.quot;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rate_r  <= in_baud_rate;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (reject) begin
            res_ok_r  <= 1'b0;
            res_exp_r <= '0;
            res_div_r <= '0;
            state_r   <= S_DONE;
          end else begin
            rate_r  <= rate2;
            state_r <= S_RATIO_WAIT;
          end
        end
        S_RATIO_WAIT: begin
          if (div_rsp.done) begin
            ratio_r <= div_rsp.quot;
            lim_r   <= LIM_INIT;
            exp_r   <= EXP_MIN;
            state_r <= S_SEARCH;
          end
        end
        // one limit step per cycle until the ratio falls below it or the exponent reaches its maximum
        S_SEARCH: begin
          if (exp_r == EXP_MAX || ratio_r < lim_r) begin
            state_r <= S_PREP;
          end else begin
            lim_r <= (lim_r << 1) | DATA_W'(exp_r < -EXP_OFS);
            exp_r <= exp_r + 4'sd1;
          end
        end
        S_PREP: begin
          nonneg_r   <= !exp_r[EXP_W-1];
          den_zero_r <= (prep_den == '0);
          state_r    <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            res_ok_r  <= 1'b1;
            res_exp_r <= exp_r;
            res_div_r <= nonneg_r ? DIVISOR_W'(q_raw - 1'b1) : q_raw[DIVISOR_W-1:0];
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_exp_r   <= res_exp_r;
            out_div_r   <= res_div_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_scale_exp = out_exp_r;
  assign out_divisor   = out_div_r;

`ifndef NO_ASSERTIONS
  // a new result only appears when the sequencer hands one over
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the hand-over state");

  // the divider is running or finishing whenever its result is awaited
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RATIO_WAIT || state_r == S_DIV_WAIT) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  // a rejected rate carries zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_scale_exp == '0 && out_divisor == '0))
    else $error("rejected item with nonzero fields");

  // exponent stays within -7 to 7
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok) |-> (out_scale_exp >= EXP_MIN && out_scale_exp <= EXP_MAX))
    else $error("scale exponent out of range");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench for fractional_baud_divider_calc: a directed stimulus table, then random
// rates over several clock and speed settings, checked against a local bsel predictor
// depends on fbd_pkg and the block's top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbd_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int ITEMS_DEAD_CLK  = 40;
  localparam int MAX_REPORTS     = 10;
  localparam int TAIL_CYCLES     = 100;

  localparam logic [DATA_W-1:0] CLK_TOP = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] CLK_16M = 32'd16000000;

  // one result item
  typedef struct packed {
    logic                 ok;
    logic [EXP_W-1:0]     scale_exp;
    logic [DIVISOR_W-1:0] divisor;
  } bsel_t;

  // one row of the directed table; want is used only where fixed is set
  typedef struct packed {
    logic [DATA_W-1:0] clock_hz;
    logic              dbl;
    logic [DATA_W-1:0] rate;
    logic              fixed;
    bsel_t             want;
  } stim_row_t;

  localparam bsel_t REJECT     = '{1'b0, 4'd0, 12'd0};
  // rate at the upper limit: ratio 8, lowest exponent, divisor 0
  localparam bsel_t TOP_OF_RANGE = '{1'b1, EXP_MIN, 12'd0};

  localparam int N_DIRECTED = 25;
  stim_row_t directed [N_DIRECTED] = '{
    '{CORE_CLOCK_RESET, 1'b0, 32'd0,          1'b1, REJECT},
    '{CORE_CLOCK_RESET, 1'b0, 32'd2,          1'b1, REJECT},
    '{CORE_CLOCK_RESET, 1'b0, 32'd3,          1'b0, REJECT},
    '{CORE_CLOCK_RESET, 1'b0, 32'd9600,       1'b0, REJECT},
    '{CORE_CLOCK_RESET, 1'b0, 32'd115200,     1'b0, REJECT},
    '{CORE_CLOCK_RESET, 1'b0, 32'd2000000,    1'b1, TOP_OF_RANGE},
    '{CORE_CLOCK_RESET, 1'b0, 32'd2000001,    1'b1, REJECT},
    '{CORE_CLOCK_RESET, 1'b0, 32'hffff_ffff,  1'b1, REJECT},
    '{CORE_CLOCK_RESET, 1'b1, 32'd4000000,    1'b1, TOP_OF_RANGE},
    '{CORE_CLOCK_RESET, 1'b1, 32'd4000001,    1'b1, REJECT},
    '{CORE_CLOCK_RESET, 1'b1, 32'd7,          1'b0, REJECT},
    '{CORE_CLOCK_RESET, 1'b1, 32'd6,          1'b1, REJECT},
    '{CLK_TOP,          1'b0, 32'd1,          1'b1, REJECT},
    '{CLK_TOP,          1'b0, 32'd511,        1'b0, REJECT},
    '{CLK_TOP,          1'b0, 32'h0fff_ffff,  1'b0, REJECT},
    '{CLK_TOP,          1'b0, 32'hffff_ffff,  1'b1, REJECT},
    '{CLK_TOP,          1'b1, 32'h1fff_ffff,  1'b0, REJECT},
    '{CLK_TOP,          1'b1, 32'd1023,       1'b0, REJECT},
    '{CLK_TOP,          1'b1, 32'h8000_0000,  1'b1, REJECT},
    '{32'd1,            1'b1, 32'd0,          1'b1, REJECT},
    '{32'd1,            1'b1, 32'd1,          1'b1, REJECT},
    '{32'd0,            1'b0, 32'd0,          1'b1, REJECT},
    '{32'd0,            1'b1, 32'd5,          1'b1, REJECT},
    '{CLK_16M,          1'b1, 32'd2000000,    1'b1, TOP_OF_RANGE},
    '{CLK_16M,          1'b1, 32'd38400,      1'b0, REJECT}
  };

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
  logic [DATA_W-1:0]     cfg_wdata     = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_baud_rate  = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic                  out_ok;
  logic signed [EXP_W-1:0] out_scale_exp;
  logic [DIVISOR_W-1:0]  out_divisor;

  // settings the block holds right now, as seen from here
  logic [DATA_W-1:0] cur_clock_hz = CORE_CLOCK_RESET;
  logic              cur_dbl      = 1'b0;

  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  bsel_t bsel_due [$];
  int    err_count = 0;
  int    cycle_cnt = 0;

  fractional_baud_divider_calc uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_baud_rate  (in_baud_rate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_scale_exp (out_scale_exp),
    .out_divisor   (out_divisor)
  );

  always #10 clk = ~clk;

  // division that yields zero for a zero divisor
  function automatic logic [DATA_W-1:0] div0(input logic [DATA_W-1:0] num,
                                             input logic [DATA_W-1:0] den);
    return (den == '0) ? '0 : num / den;
  endfunction

  // expected scale exponent and divisor for one rate, 32-bit wrapping throughout
  function automatic bsel_t bsel_calc(input logic [DATA_W-1:0] rate_req,
                                      input logic [DATA_W-1:0] clock_hz,
                                      input logic              dbl);
    logic [DATA_W-1:0] rate, hi, lo, lim, ratio, rem, q;
    int                e;
    bsel_t             r;
    r  = REJECT;
    hi = clock_hz >> MAX_DIV_SH;
    lo = clock_hz >> MIN_DIV_SH;
    if (!dbl) begin
      hi = hi >> 1;
      lo = lo >> 1;
    end
    // out of range, and a zero rate
    if (rate_req > hi || rate_req < lo || rate_req == '0) return r;
    rate  = dbl ? rate_req : rate_req << 1;
    lim   = LIM_INIT;
    ratio = clock_hz / rate;
    // lowest exponent whose limit the ratio falls below, else the highest
    for (e = int'(EXP_MIN); e < int'(EXP_MAX); e++) begin
      if (ratio < lim) break;
      lim = lim << 1;
      if (e < -int'(EXP_OFS)) lim = lim | 32'd1;
    end
    if (e < 0) begin
      rem = clock_hz - (rate << MAX_DIV_SH);
      if (e <= -int'(EXP_OFS)) begin
        q = div0((rem << (-e - int'(EXP_OFS))) + (rate >> 1), rate);
      end else begin
        rate = rate << (e + int'(EXP_OFS));
        q    = div0(rem + (rate >> 1), rate);
      end
    end else begin
      // quotient minus one, wrapping to all ones on a zero quotient
      rate = rate << (e + int'(EXP_OFS));
      q    = div0(clock_hz + (rate >> 1), rate) - 32'd1;
    end
    r.ok        = 1'b1;
    r.scale_exp = e[EXP_W-1:0];
    r.divisor   = q[DIVISOR_W-1:0];
    return r;
  endfunction

  // random rate: mostly inside the legal span, some at its edges, some anywhere
  function automatic logic [DATA_W-1:0] pick_rate(input logic [DATA_W-1:0] clock_hz,
                                                  input logic              dbl);
    logic [DATA_W-1:0] hi, lo, span;
    int                sel;
    hi  = clock_hz >> MAX_DIV_SH;
    lo  = clock_hz >> MIN_DIV_SH;
    sel = $urandom_range(99);
    if (!dbl) begin
      hi = hi >> 1;
      lo = lo >> 1;
    end
    if (sel < 15) return $urandom;
    if (sel < 30) begin
      case ($urandom_range(3))
        0:       return lo - 32'd1;
        1:       return lo;
        2:       return hi;
        default: return hi + 32'd1;
      endcase
    end
    if (hi < lo) return $urandom >> $urandom_range(31);
    span = hi - lo + 32'd1;
    return lo + (($urandom >> $urandom_range(31)) % span);
  endfunction

  // write both registers once the block has nothing outstanding
  task automatic set_divider_cfg(input logic [DATA_W-1:0] clock_hz, input logic dbl);
    while (bsel_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_CORE_CLOCK;
    cfg_wdata <= clock_hz;
    @(posedge clk);
    cfg_addr  <= REG_DOUBLE_SPEED;
    cfg_wdata <= {31'($urandom), dbl};
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_clock_hz = clock_hz;
    cur_dbl      = dbl;
  endtask

  // offer one rate, wait for it to be taken, then maybe idle a while
  task automatic send_rate(input logic [DATA_W-1:0] rate, input logic fixed,
                           input bsel_t want);
    in_valid     <= 1'b1;
    in_baud_rate <= rate;
    do @(posedge clk); while (in_stall);
    bsel_due.push_back(fixed ? want : bsel_calc(rate, cur_clock_hz, cur_dbl));
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_baud_rate <= $urandom;
      @(posedge clk);
    end
  endtask

  // stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    logic [DATA_W-1:0] clk_sel;
    logic              dbl_sel;
    int                n_items;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].clock_hz != cur_clock_hz || directed[i].dbl != cur_dbl) begin
        in_valid <= 1'b0;
        set_divider_cfg(directed[i].clock_hz, directed[i].dbl);
      end
      send_rate(directed[i].rate, directed[i].fixed, directed[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      n_items = ITEMS_PER_PHASE;
      case (ph)
        0: begin
          clk_sel = CORE_CLOCK_RESET;
          dbl_sel = 1'b0;
        end
        1: begin
          clk_sel = CLK_TOP;
          dbl_sel = 1'b1;
        end
        2: begin
          // every rate rejected at this clock
          clk_sel = 32'd1;
          dbl_sel = 1'b0;
          n_items = ITEMS_DEAD_CLK;
        end
        4: begin
          clk_sel = CLK_16M;
          dbl_sel = 1'b1;
        end
        5: begin
          clk_sel = CLK_TOP;
          dbl_sel = 1'b0;
        end
        default: begin
          clk_sel = ($urandom >> $urandom_range(12)) | 32'd1;
          dbl_sel = 1'($urandom_range(1));
        end
      endcase
      in_valid <= 1'b0;
      set_divider_cfg(clk_sel, dbl_sel);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      for (int n = 0; n < n_items; n++)
        send_rate(pick_rate(cur_clock_hz, cur_dbl), 1'b0, REJECT);
    end

    in_valid <= 1'b0;
    while (bsel_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && bsel_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // result check against the oldest expectation, and receiver stalls
  always @(posedge clk) begin : result_check
    bsel_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_ok, out_scale_exp, out_divisor};
      if (bsel_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("tb: unexpected item ok=%0b exp=%0d div=%0d",
                   got.ok, $signed(got.scale_exp), got.divisor);
      end else begin
        want = bsel_due.pop_front();
        if (got.ok !== want.ok || got.scale_exp !== want.scale_exp ||
            got.divisor !== want.divisor) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("tb: mismatch ok=%0b/%0b exp=%0d/%0d div=%0d/%0d (expected/actual)",
                     want.ok, got.ok, $signed(want.scale_exp), $signed(got.scale_exp),
                     want.divisor, got.divisor);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // cycle limit
  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule
